/* src/lpl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types, character codes and helper functions of the lexer.
// ----------------------------------------------------------------------------
package lpl_pkg;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        K_OPEN   = 4'd0,
        K_CLOSE  = 4'd1,
        K_SYMBOL = 4'd2,
        K_FLOAT  = 4'd3,
        K_INT    = 4'd4,
        K_FALSE  = 4'd5,
        K_TRUE   = 4'd6,
        K_STRING = 4'd7,
        K_ERROR  = 4'd8,
        K_END    = 4'd9
    } t_kind;

    // Error codes carried by error tokens.
    typedef enum logic [1:0] {
        E_NONE         = 2'd0,
        E_UNKNOWN      = 2'd1,
        E_BAD_EXP      = 2'd2,
        E_UNTERMINATED = 2'd3
    } t_err;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        t_err        err;
        logic        last;
    } t_result;

    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Results produced by one accepted byte.
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic    [1:0]         cnt;
    } t_step_out;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Letters of the keyword "true".
    function automatic logic [7:0] true_char(input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0: c = 8'h74;
            2'd1: c = 8'h72;
            2'd2: c = 8'h75;
            2'd3: c = 8'h65;
        endcase
        return c;
    endfunction

    // Letters of the keyword "false".
    function automatic logic [7:0] false_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_result mk_res(input t_kind kind, input t_err err,
                                       input logic [31:0] start, input logic [31:0] len,
                                       input logic [31:0] line, input logic [31:0] col);
        t_result r;
        r.kind  = kind;
        r.start = clamp16(start);
        r.len   = clamp16(len);
        r.line  = clamp16(line);
        r.col   = clamp16(col);
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

/* src/lpl_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_scanner
// Scanner state, position counters and the per-byte token logic.
// ----------------------------------------------------------------------------
module lpl_scanner
    import lpl_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int LINE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    output t_step_out  o_step
);

    typedef enum logic [2:0] {
        S_IDLE, S_COMMENT, S_NUMBER, S_EXP, S_EXPSIGN, S_ALPHA, S_STRING, S_DEAD
    } t_mode;

    localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]  POS_ONE  = POS_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    t_mode                r_mode, n_mode;
    logic [POS_BITS-1:0]  r_pos, n_pos, r_tok_start, n_tok_start, r_tok_len, n_tok_len;
    logic [LINE_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [LINE_BITS-1:0] r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [1:0]           r_flags, n_flags, r_kw, n_kw;

    logic                  restart, failed;
    t_result [MAX_RES-1:0] res;
    logic [1:0]            cnt;
    t_kind                 num_kind, word_kind;

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        n_tok_start = r_tok_start;
        n_tok_line  = r_tok_line;
        n_tok_col   = r_tok_col;
        n_tok_len   = r_tok_len;
        n_flags     = r_flags;
        n_kw        = r_kw;
        restart     = 1'b0;
        failed      = 1'b0;
        res         = '0;
        cnt         = 2'd0;
        num_kind    = K_INT;
        word_kind   = K_SYMBOL;

        unique case (r_mode)
            S_COMMENT: begin
                if (i_char == CH_LF) begin
                    n_mode = S_IDLE;
                end
            end
            S_STRING: begin
                n_tok_len = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                if (i_char == CH_QUOTE) begin
                    res[cnt] = mk_res(K_STRING, E_NONE, 32'(n_tok_start), 32'(n_tok_len),
                                      32'(n_tok_line), 32'(n_tok_col));
                    cnt      = cnt + 2'd1;
                    n_mode   = S_IDLE;
                end
            end
            S_NUMBER: begin
                if (i_char == CH_DOT && !n_flags[0]) begin
                    n_flags[0] = 1'b1;
                    n_tok_len  = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                end else if ((i_char == CH_LOW_E || i_char == CH_UP_E) && !n_flags[1]) begin
                    n_flags[1] = 1'b1;
                    n_mode     = S_EXP;
                    n_tok_len  = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                end else if (!is_digit(i_char)) begin
                    num_kind = (n_flags != 2'b00) ? K_FLOAT : K_INT;
                    res[cnt] = mk_res(num_kind, E_NONE, 32'(n_tok_start), 32'(n_tok_len),
                                      32'(n_tok_line), 32'(n_tok_col));
                    cnt      = cnt + 2'd1;
                    n_mode   = S_IDLE;
                    restart  = 1'b1;
                end else begin
                    n_tok_len = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                end
            end
            S_EXP, S_EXPSIGN: begin
                n_tok_len = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                if (r_mode == S_EXP && (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                    n_mode = S_EXPSIGN;
                end else if (is_digit(i_char)) begin
                    n_mode = S_NUMBER;
                end else begin
                    res[cnt] = mk_res(K_ERROR, E_BAD_EXP, 32'(n_tok_start), 32'(n_tok_len),
                                      32'(n_tok_line), 32'(n_tok_col));
                    cnt      = cnt + 2'd1;
                    n_mode   = S_DEAD;
                end
            end
            S_ALPHA: begin
                if (is_alpha(i_char) || is_digit(i_char) || i_char == CH_UNDER
                        || i_char == CH_MINUS || i_char == CH_QMARK) begin
                    // A keyword candidate dies at a mismatch or an extra letter.
                    if (n_kw == 2'd1) begin
                        if (n_tok_len >= POS_BITS'(4)
                                || true_char(n_tok_len[1:0]) != i_char) begin
                            n_kw = 2'd0;
                        end
                    end else if (n_kw == 2'd2) begin
                        if (n_tok_len >= POS_BITS'(5)
                                || false_char(n_tok_len[2:0]) != i_char) begin
                            n_kw = 2'd0;
                        end
                    end
                    n_tok_len = (n_tok_len < POS_MAX) ? n_tok_len + POS_ONE : POS_MAX;
                end else begin
                    if (n_kw == 2'd1 && n_tok_len == POS_BITS'(4)) begin
                        word_kind = K_TRUE;
                    end else if (n_kw == 2'd2 && n_tok_len == POS_BITS'(5)) begin
                        word_kind = K_FALSE;
                    end
                    res[cnt] = mk_res(word_kind, E_NONE, 32'(n_tok_start), 32'(n_tok_len),
                                      32'(n_tok_line), 32'(n_tok_col));
                    cnt      = cnt + 2'd1;
                    n_mode   = S_IDLE;
                    restart  = 1'b1;
                end
            end
            S_DEAD: begin
            end
            S_IDLE: begin
                restart = 1'b1;
            end
        endcase

        // A byte that ends a number or symbol, or any byte seen between
        // tokens, is lexed as the start of a new token.
        if (restart) begin
            n_tok_start = r_pos;
            n_tok_line  = r_line;
            n_tok_col   = r_col;
            n_tok_len   = POS_ONE;
            n_flags     = 2'b00;
            n_kw        = 2'd0;
            priority if (is_space(i_char)) begin
            end else if (i_char == CH_SEMI) begin
                n_mode = S_COMMENT;
            end else if (i_char == CH_LPAREN || i_char == CH_RPAREN) begin
                res[cnt] = mk_res((i_char == CH_LPAREN) ? K_OPEN : K_CLOSE, E_NONE,
                                  32'(n_tok_start), 32'(n_tok_len),
                                  32'(n_tok_line), 32'(n_tok_col));
                if (cnt != 2'd3) begin
                    cnt = cnt + 2'd1;
                end
            end else if (is_digit(i_char) || i_char == CH_PLUS || i_char == CH_MINUS) begin
                n_mode = S_NUMBER;
            end else if (is_alpha(i_char) || i_char == CH_UNDER) begin
                n_mode = S_ALPHA;
                n_kw   = (i_char == CH_LOW_T) ? 2'd1 : (i_char == CH_LOW_F) ? 2'd2 : 2'd0;
            end else if (i_char == CH_QUOTE) begin
                n_mode = S_STRING;
            end else begin
                res[cnt] = mk_res(K_ERROR, E_UNKNOWN, 32'(n_tok_start), 32'(n_tok_len),
                                  32'(n_tok_line), 32'(n_tok_col));
                if (cnt != 2'd3) begin
                    cnt = cnt + 2'd1;
                end
                n_mode = S_DEAD;
            end
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_ONE : POS_MAX;
        if (i_char == CH_LF) begin
            n_line = (r_line < LINE_MAX) ? r_line + LINE_ONE : LINE_MAX;
            n_col  = LINE_ONE;
        end else begin
            n_col  = (r_col < LINE_MAX) ? r_col + LINE_ONE : LINE_MAX;
        end

        if (i_eoi) begin
            failed = (n_mode == S_DEAD);
            if (n_mode == S_NUMBER) begin
                num_kind = (n_flags != 2'b00) ? K_FLOAT : K_INT;
                res[cnt] = mk_res(num_kind, E_NONE, 32'(n_tok_start), 32'(n_tok_len),
                                  32'(n_tok_line), 32'(n_tok_col));
                cnt      = cnt + 2'd1;
            end else if (n_mode == S_ALPHA) begin
                if (n_kw == 2'd1 && n_tok_len == POS_BITS'(4)) begin
                    word_kind = K_TRUE;
                end else if (n_kw == 2'd2 && n_tok_len == POS_BITS'(5)) begin
                    word_kind = K_FALSE;
                end
                res[cnt] = mk_res(word_kind, E_NONE, 32'(n_tok_start), 32'(n_tok_len),
                                  32'(n_tok_line), 32'(n_tok_col));
                cnt      = cnt + 2'd1;
            end else if (n_mode == S_EXP || n_mode == S_EXPSIGN) begin
                res[cnt] = mk_res(K_ERROR, E_BAD_EXP, 32'(n_tok_start), 32'(n_tok_len),
                                  32'(n_tok_line), 32'(n_tok_col));
                cnt      = cnt + 2'd1;
                failed   = 1'b1;
            end else if (n_mode == S_STRING) begin
                res[cnt] = mk_res(K_ERROR, E_UNTERMINATED, 32'(n_tok_start),
                                  32'(n_tok_len), 32'(n_tok_line), 32'(n_tok_col));
                cnt      = cnt + 2'd1;
                failed   = 1'b1;
            end
            if (!failed && cnt != 2'd3) begin
                res[cnt] = mk_res(K_END, E_NONE, 32'(n_pos), 32'd0, 32'(n_line), 32'(n_col));
                cnt      = cnt + 2'd1;
            end
            n_mode      = S_IDLE;
            n_pos       = '0;
            n_line      = LINE_ONE;
            n_col       = LINE_ONE;
            n_tok_start = '0;
            n_tok_line  = LINE_ONE;
            n_tok_col   = LINE_ONE;
            n_tok_len   = '0;
            n_flags     = 2'b00;
            n_kw        = 2'd0;
        end

        for (int k = 0; k < MAX_RES; k++) begin
            res[k].last = ((2'(k) + 2'd1) == cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= S_IDLE;
            r_pos       <= '0;
            r_line      <= LINE_ONE;
            r_col       <= LINE_ONE;
            r_tok_start <= '0;
            r_tok_line  <= LINE_ONE;
            r_tok_col   <= LINE_ONE;
            r_tok_len   <= '0;
            r_flags     <= 2'b00;
            r_kw        <= 2'd0;
        end else if (i_take) begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_line      <= n_line;
            r_col       <= n_col;
            r_tok_start <= n_tok_start;
            r_tok_line  <= n_tok_line;
            r_tok_col   <= n_tok_col;
            r_tok_len   <= n_tok_len;
            r_flags     <= n_flags;
            r_kw        <= n_kw;
        end
    end

    assign o_step.res = res;
    assign o_step.cnt = i_take ? cnt : 2'd0;

endmodule

/* src/lpl_res_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_res_queue
// Small result queue: takes up to three results a cycle, gives one.
// ----------------------------------------------------------------------------
module lpl_res_queue
    import lpl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_out         i_push,
    input  logic              i_pop,
    output t_result           o_head,
    output logic              o_valid,
    output logic [QCNT_W-1:0] o_count
);

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_rd, r_wr;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push.cnt);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[r_wr + QPTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

/* src/lisp_token_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisp_token_lexer
// S-expression lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
// Tokens a byte causes are written to the result queue at the clock edge that
// takes the byte. Throughput: one byte per cycle while the queue has room; a
// byte may cause up to three tokens, which leave one per cycle while i_ready
// is high, so the output port sets the rate when bytes produce more than one
// token each. Input is taken while the result queue holds at most one
// token. Synchronous active-low reset clears scan state, counters and queue.
// ----------------------------------------------------------------------------
module lisp_token_lexer
    import lpl_pkg::*;
#(
    parameter int POS_BITS  = 16,
    parameter int LINE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Source byte channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_input,
    // Token channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic [1:0]  o_error_code,
    output logic        o_run_last
);

    // The scanner holds the lexing state machine together with the offset,
    // line and column counters. All work for one byte is done in a single
    // combinational pass from those registers, and the tokens it yields are
    // written into the result queue at the same clock edge as the state
    // update. The queue then parts the two sides, so the source may keep
    // sending while a finished token waits for the consumer.
    t_step_out         step;
    t_result           head;
    logic              take;
    logic [QCNT_W-1:0] q_count;

    // A byte may produce three tokens, so there must be three free slots
    // before a transaction is taken.
    assign o_ready = (q_count <= QCNT_W'(QDEPTH - MAX_RES));
    assign take    = i_valid && o_ready;

    lpl_scanner #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_char_byte),
        .i_eoi   (i_end_of_input),
        .o_step  (step)
    );

    lpl_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_pop   (i_ready),
        .o_head  (head),
        .o_valid (o_valid),
        .o_count (q_count)
    );

    // Counters are already clamped to sixteen bits inside the result record.
    assign o_token_kind    = head.kind;
    assign o_start_offset  = head.start;
    assign o_token_length  = head.len;
    assign o_line_number   = head.line;
    assign o_column_number = head.col;
    assign o_error_code    = head.err;
    assign o_run_last      = head.last;

    // The queue can never hold more tokens than it has slots.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // An error code appears on error tokens and on nothing else.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_token_kind == K_ERROR) == (o_error_code != E_NONE)))
        else $error("error code does not match token kind");

    // Lines and columns count from one.
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_number != 16'd0 && o_column_number != 16'd0))
        else $error("token reports line or column zero");

    // Reset empties the queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token offered straight after reset");

endmodule
